@@ sv/hbr_pkg.sv @@
// shared constants, types and helpers of the byte range parser
package hbr_pkg;

  localparam int FIELD_W     = 48;
  localparam int OFFSET_BITS = 48;
  localparam int SIZE_W      = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;
  localparam int ACC_W       = OFFSET_BITS + 4;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [FIELD_W-1:0]     field_t;

  localparam offset_t OFFSET_MAX = '1;

  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [2:0] PREFIX_LAST = 3'd5;
  localparam logic [2:0] PREFIX_LEN  = 3'd6;
  localparam logic [2:0] MIN_LEN     = 3'd7;

  // "bytes="
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h79;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h3d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ sv/hbr_ifs.sv @@
// valid/ready channels for header bytes and parsed ranges
interface hbr_in_if import hbr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       present;
  logic [7:0] value_byte;
  logic       is_last;
  field_t     object_size;

  modport source (output valid, present, value_byte, is_last, object_size, input ready);
  modport sink   (input valid, present, value_byte, is_last, object_size, output ready);
endinterface

interface hbr_out_if import hbr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   range_ok;
  field_t range_first;
  field_t range_final;

  modport source (output valid, range_ok, range_first, range_final, input ready);
  modport sink   (input valid, range_ok, range_first, range_final, output ready);
endinterface

@@ sv/http_byte_range_parser_core.sv @@
// http range header parser: byte stream in, one range word per header out
//
// req carries one header byte per word, with present, is_last and the file
// size; a word with present low stands for an absent or empty header and
// ends the request at once. rsp carries one word per request: range_ok and
// the inclusive first and final offsets, both zero when no valid range.
// one byte is taken every cycle while req.ready is high; a header of
// n bytes costs n words on req. the result is offered on rsp by the
// output register. the byte sits in the input register while the parser
// folds it into the decimal accumulators (multiply by ten, add, saturate)
// on the way to the check stage; the range check fills the output register.
// when rsp stalls, the finished result waits in the output register, one
// more in the check stage, and bytes that do not end a header keep flowing;
// req.ready drops only when a further result would have nowhere to go.
// reset (rst, synchronous) empties every stage and returns the parser to
// the prefix phase with cleared accumulators.
module http_byte_range_parser_core import hbr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hbr_in_if.sink     req,
  hbr_out_if.source  rsp
);

  typedef enum logic [1:0] {PH_PREFIX, PH_FIRST, PH_SECOND, PH_BAD} phase_t;

  // input register
  logic       s1_valid;
  logic       s1_present;
  logic [7:0] s1_byte;
  logic       s1_last;
  field_t     s1_size;

  // parser state
  phase_t     phase, phase_next;
  logic [2:0] byte_count, byte_count_next;
  offset_t    first_accum, first_accum_next;
  offset_t    second_accum, second_accum_next;
  logic       first_has_digits, first_has_digits_next;
  logic       second_has_digits, second_has_digits_next;

  // check stage
  logic    fin_valid;
  logic    fin_ok;
  logic    fin_first_has;
  logic    fin_second_has;
  offset_t fin_first;
  offset_t fin_second;
  offset_t fin_size;

  // output register
  logic   out_valid;
  logic   out_ok;
  field_t out_first;
  field_t out_final;

  logic    out_free, fin_free, s1_end, s1_go;
  logic    is_digit;
  logic [3:0] digit;
  logic [SIZE_W-1:0] size_ext;
  offset_t size_sat;
  logic    fin_ok_next;

  offset_t size_m1, start_off, end_off, end_clamped;
  logic    range_good;

  function automatic offset_t accumulate(input offset_t acc, input logic [3:0] d);
    logic [ACC_W-1:0] wide;
    wide = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(d);
    if (wide > ACC_W'(OFFSET_MAX)) begin
      return OFFSET_MAX;
    end
    return offset_t'(wide);
  endfunction

  assign out_free  = !out_valid || rsp.ready;
  assign fin_free  = !fin_valid || out_free;
  assign s1_end    = !s1_present || s1_last;
  assign s1_go     = s1_valid && (!s1_end || fin_free);
  assign req.ready = !s1_valid || s1_go;

  assign rsp.valid       = out_valid;
  assign rsp.range_ok    = out_ok;
  assign rsp.range_first = out_first;
  assign rsp.range_final = out_final;

  // parser update
  always_comb begin
    is_digit = (s1_byte >= CH_ZERO) && (s1_byte <= CH_NINE);
    digit    = 4'(s1_byte - CH_ZERO);

    phase_next             = phase;
    first_accum_next       = first_accum;
    second_accum_next      = second_accum;
    first_has_digits_next  = first_has_digits;
    second_has_digits_next = second_has_digits;

    unique case (phase)
      PH_PREFIX: begin
        if (byte_count < PREFIX_LEN && s1_byte == prefix_char(byte_count)) begin
          if (byte_count == PREFIX_LAST) begin
            phase_next = PH_FIRST;
          end
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_FIRST: begin
        if (is_digit) begin
          first_accum_next      = accumulate(first_accum, digit);
          first_has_digits_next = 1'b1;
        end else if (s1_byte == CH_DASH) begin
          phase_next = PH_SECOND;
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_SECOND: begin
        if (is_digit) begin
          second_accum_next      = accumulate(second_accum, digit);
          second_has_digits_next = 1'b1;
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_BAD: begin
      end
      default: begin
        phase_next = PH_BAD;
      end
    endcase

    byte_count_next = (byte_count == MIN_LEN) ? byte_count : byte_count + 3'd1;

    size_ext = SIZE_W'(s1_size);
    size_sat = (size_ext > SIZE_W'(OFFSET_MAX)) ? OFFSET_MAX : offset_t'(size_ext);

    fin_ok_next = s1_present && (byte_count_next == MIN_LEN) &&
                  (phase_next == PH_SECOND) && (size_sat != '0);
  end

  // range check
  always_comb begin
    size_m1    = fin_size - offset_t'(1);
    range_good = fin_ok;
    if (!fin_first_has) begin
      if (fin_second == '0) begin
        range_good = 1'b0;
      end
      start_off = (fin_second >= fin_size) ? '0 : fin_size - fin_second;
      end_off   = size_m1;
    end else begin
      start_off = fin_first;
      end_off   = fin_second_has ? fin_second : size_m1;
    end
    if (start_off >= fin_size || start_off > end_off) begin
      range_good = 1'b0;
    end
    end_clamped = (end_off >= fin_size) ? size_m1 : end_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      fin_valid         <= 1'b0;
      out_valid         <= 1'b0;
      phase             <= PH_PREFIX;
      byte_count        <= '0;
      first_accum       <= '0;
      second_accum      <= '0;
      first_has_digits  <= 1'b0;
      second_has_digits <= 1'b0;
    end else begin
      // input register
      if (req.valid && req.ready) begin
        s1_valid   <= 1'b1;
        s1_present <= req.present;
        s1_byte    <= req.value_byte;
        s1_last    <= req.is_last;
        s1_size    <= req.object_size;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      // parser
      if (s1_go) begin
        if (s1_end) begin
          phase             <= PH_PREFIX;
          byte_count        <= '0;
          first_accum       <= '0;
          second_accum      <= '0;
          first_has_digits  <= 1'b0;
          second_has_digits <= 1'b0;
          fin_ok            <= fin_ok_next;
          fin_first_has     <= first_has_digits_next;
          fin_second_has    <= second_has_digits_next;
          fin_first         <= first_accum_next;
          fin_second        <= second_accum_next;
          fin_size          <= size_sat;
        end else begin
          phase             <= phase_next;
          byte_count        <= byte_count_next;
          first_accum       <= first_accum_next;
          second_accum      <= second_accum_next;
          first_has_digits  <= first_has_digits_next;
          second_has_digits <= second_has_digits_next;
        end
      end

      // check stage
      if (s1_go && s1_end) begin
        fin_valid <= 1'b1;
      end else if (out_free) begin
        fin_valid <= 1'b0;
      end

      // output register
      if (out_free) begin
        out_valid <= fin_valid;
        if (fin_valid) begin
          out_ok    <= range_good;
          out_first <= range_good ? FIELD_W'(start_off) : '0;
          out_final <= range_good ? FIELD_W'(end_clamped) : '0;
        end
      end
    end
  end

endmodule

@@ sim/tb_http_byte_range_parser_core.sv @@
// testbench of the byte range parser: random and directed headers, scoreboard check
module tb_http_byte_range_parser_core;
  import hbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT_CYCLES = 200000;
  localparam int          SETTLE       = 10;
  localparam int          LONG_HOLD    = 400;
  localparam int          UNIT_LEN     = 6;
  localparam int          MIN_HDR_LEN  = 7;
  localparam logic [47:0] UNIT_TEXT    = "bytes=";
  localparam logic [7:0]  ASCII_DASH   = "-";
  localparam logic [7:0]  ASCII_ZERO   = "0";
  localparam logic [7:0]  ASCII_NINE   = "9";

  typedef logic [63:0] wide_t;

  typedef enum logic [1:0] {SCAN_PREFIX, SCAN_FIRST, SCAN_SECOND, SCAN_BAD} scan_t;

  typedef struct packed {
    logic       present;
    logic [7:0] value_byte;
    logic       is_last;
    field_t     object_size;
  } hdr_word_t;

  typedef struct packed {
    logic   range_ok;
    field_t range_first;
    field_t range_final;
  } range_t;

  logic clk = 1'b0;
  logic rst;

  hbr_in_if  req_ch ();
  hbr_out_if rsp_ch ();

  http_byte_range_parser_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #4 clk = ~clk;

  hdr_word_t   pending_words[$];
  range_t      expected_ranges[$];
  hdr_word_t   next_word;
  int unsigned words_queued  = 0;
  int unsigned src_idle_pct  = 30;
  int unsigned sink_idle_pct = 47;
  int unsigned hold_kick     = 0;
  int unsigned kick_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  logic        word_taken    = 1'b0;

  // parser state of the predictor
  scan_t      scan_phase;
  logic [2:0] seen_bytes;
  wide_t      lead_acc;
  wide_t      tail_acc;
  logic       lead_digits;
  logic       tail_digits;

  function automatic wide_t add_digit(wide_t acc, wide_t d);
    wide_t lim;
    lim = wide_t'(OFFSET_MAX);
    if (acc > (lim - d) / 10) return lim;
    return acc * 10 + d;
  endfunction

  task automatic clear_scan();
    scan_phase  = SCAN_PREFIX;
    seen_bytes  = '0;
    lead_acc    = '0;
    tail_acc    = '0;
    lead_digits = 1'b0;
    tail_digits = 1'b0;
  endtask

  task automatic predict_range(input hdr_word_t w);
    wide_t  size, start, stop;
    logic   ok, dig;
    range_t r;
    start = '0;
    stop  = '0;
    if (!w.present) begin
      clear_scan();
      expected_ranges.push_back('0);
      return;
    end
    dig = (w.value_byte >= ASCII_ZERO) && (w.value_byte <= ASCII_NINE);
    case (scan_phase)
      SCAN_PREFIX: begin
        if (seen_bytes < UNIT_LEN &&
            w.value_byte == UNIT_TEXT[8*(UNIT_LEN-1-int'(seen_bytes)) +: 8]) begin
          if (seen_bytes == UNIT_LEN - 1) scan_phase = SCAN_FIRST;
        end else begin
          scan_phase = SCAN_BAD;
        end
      end
      SCAN_FIRST: begin
        if (dig) begin
          lead_acc    = add_digit(lead_acc, wide_t'(w.value_byte - ASCII_ZERO));
          lead_digits = 1'b1;
        end else if (w.value_byte == ASCII_DASH) begin
          scan_phase = SCAN_SECOND;
        end else begin
          scan_phase = SCAN_BAD;
        end
      end
      SCAN_SECOND: begin
        if (dig) begin
          tail_acc    = add_digit(tail_acc, wide_t'(w.value_byte - ASCII_ZERO));
          tail_digits = 1'b1;
        end else begin
          scan_phase = SCAN_BAD;
        end
      end
      default: ;
    endcase
    if (seen_bytes < MIN_HDR_LEN) seen_bytes = seen_bytes + 1'b1;
    if (!w.is_last) return;

    size = wide_t'(w.object_size);
    if (size > wide_t'(OFFSET_MAX)) size = wide_t'(OFFSET_MAX);
    ok = 1'b0;
    if (seen_bytes < MIN_HDR_LEN || scan_phase != SCAN_SECOND || size == 0) begin
      ok = 1'b0;
    end else if (!lead_digits) begin
      if (tail_acc != 0) begin
        start = (tail_acc >= size) ? '0 : size - tail_acc;
        stop  = size - 1;
        ok    = 1'b1;
      end
    end else begin
      start = lead_acc;
      stop  = tail_digits ? tail_acc : size - 1;
      ok    = 1'b1;
    end
    if (ok && (start >= size || start > stop)) ok = 1'b0;
    if (ok && stop >= size) stop = size - 1;
    r.range_ok    = ok;
    r.range_first = ok ? field_t'(start) : '0;
    r.range_final = ok ? field_t'(stop) : '0;
    expected_ranges.push_back(r);
    clear_scan();
  endtask

  task automatic check_range();
    range_t exp;
    if (expected_ranges.size() == 0) begin
      $error("range word with nothing expected: ok %0d first %0d final %0d",
             rsp_ch.range_ok, rsp_ch.range_first, rsp_ch.range_final);
      fail_count++;
      return;
    end
    exp = expected_ranges.pop_front();
    if (rsp_ch.range_ok !== exp.range_ok) begin
      $error("range_ok: expected %0d, got %0d", exp.range_ok, rsp_ch.range_ok);
      fail_count++;
    end
    if (rsp_ch.range_first !== exp.range_first) begin
      $error("range_first: expected %0d, got %0d", exp.range_first, rsp_ch.range_first);
      fail_count++;
    end
    if (rsp_ch.range_final !== exp.range_final) begin
      $error("range_final: expected %0d, got %0d", exp.range_final, rsp_ch.range_final);
      fail_count++;
    end
  endtask

  function automatic field_t rand_field();
    return field_t'({$urandom, $urandom});
  endfunction

  task automatic queue_word(input logic present, input logic [7:0] b, input logic last,
                            input field_t size);
    hdr_word_t w;
    w.present     = present;
    w.value_byte  = b;
    w.is_last     = last;
    w.object_size = size;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_absent();
    queue_word(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)), rand_field());
  endtask

  task automatic queue_bytes(input logic [7:0] q[$], input field_t size, input logic close);
    if (q.size() == 0) begin
      queue_absent();
      return;
    end
    foreach (q[i]) begin
      if (close && i == q.size() - 1) queue_word(1'b1, q[i], 1'b1, size);
      else queue_word(1'b1, q[i], 1'b0, rand_field());
    end
  endtask

  task automatic queue_text(input string s, input field_t size, input logic close);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    queue_bytes(q, size, close);
  endtask

  function automatic field_t rand_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return field_t'(1);
    if (pick < 26) return rand_field();
    if (pick < 32) return OFFSET_MAX;
    return field_t'($urandom_range(5000, 1));
  endfunction

  function automatic string rand_number();
    int unsigned pick, n;
    string s;
    pick = $urandom_range(99);
    s = "";
    if (pick < 25) return s;
    if (pick < 35) return "0";
    if (pick < 88) return $sformatf("%0d", $urandom_range(6000));
    n = $urandom_range(20, 10);
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  task automatic queue_random_header();
    int unsigned pick, n;
    logic [7:0]  q[$];
    string       s;
    field_t      size;
    pick = $urandom_range(99);
    size = rand_size();
    if (pick < 8) begin
      queue_absent();
      return;
    end
    if (pick < 15) begin
      n = $urandom_range(10, 1);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
      queue_bytes(q, size, 1'b1);
      return;
    end
    s = {"bytes=", rand_number(), "-", rand_number()};
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    if (pick < 30) begin
      q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
    end else if (pick < 35) begin
      n = $urandom_range(q.size() - 1, 1);
      while (q.size() > n) q.delete(q.size() - 1);
    end else if (pick < 40) begin
      n = $urandom_range(q.size() - 1, 1);
      while (q.size() > n) q.delete(q.size() - 1);
      queue_bytes(q, size, 1'b0);
      queue_absent();
      return;
    end
    queue_bytes(q, size, 1'b1);
  endtask

  task automatic queue_random_batch(input int unsigned n);
    int unsigned target;
    target = words_queued + n;
    while (words_queued < target) queue_random_header();
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || req_ch.valid || expected_ranges.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // driver of the header byte channel
  always @(negedge clk) begin
    if (!rst && (!req_ch.valid || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_word = pending_words.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.present     <= next_word.present;
        req_ch.value_byte  <= next_word.value_byte;
        req_ch.is_last     <= next_word.is_last;
        req_ch.object_size <= next_word.object_size;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver side ready, with a long hold on request
  always @(negedge clk) begin
    if (hold_kick != kick_seen) begin
      kick_seen    <= hold_kick;
      hold_left    <= LONG_HOLD;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    word_taken <= req_ch.valid && req_ch.ready && !rst;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) check_range();
      if (req_ch.valid && req_ch.ready)
        predict_range({req_ch.present, req_ch.value_byte, req_ch.is_last,
                       req_ch.object_size});
    end
  end

  initial begin
    logic [7:0] edge_bytes[$];
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.present     = 1'b0;
    req_ch.value_byte  = '0;
    req_ch.is_last     = 1'b0;
    req_ch.object_size = '0;
    rsp_ch.ready       = 1'b0;
    clear_scan();
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // directed cases
    queue_text("bytes=0-99", field_t'(1000), 1'b1);
    queue_text("bytes=100-", field_t'(1000), 1'b1);
    queue_text("bytes=-100", field_t'(1000), 1'b1);
    queue_text("bytes=-5000", field_t'(1000), 1'b1);
    queue_text("bytes=-0", field_t'(1000), 1'b1);
    queue_text("bytes=-", field_t'(1000), 1'b1);
    queue_text("bytes=5", field_t'(1000), 1'b1);
    queue_text("bytes=", field_t'(1000), 1'b1);
    queue_text("b", field_t'(1000), 1'b1);
    queue_text("Bytes=0-1", field_t'(1000), 1'b1);
    queue_text("bytes=1x-2", field_t'(1000), 1'b1);
    queue_text("bytes=1-2-3", field_t'(1000), 1'b1);
    queue_text("bytes=0-0", '0, 1'b1);
    queue_text("bytes=1000-", field_t'(1000), 1'b1);
    queue_text("bytes=50-10", field_t'(1000), 1'b1);
    queue_text("bytes=0-99999999999999999999999", OFFSET_MAX, 1'b1);
    queue_text("bytes=99999999999999999999-", OFFSET_MAX, 1'b1);
    queue_text("bytes=-281474976710655", OFFSET_MAX, 1'b1);
    queue_text("bytes=0-", field_t'(1), 1'b1);
    queue_text("bytes=0-", OFFSET_MAX, 1'b1);
    queue_absent();
    queue_text("bytes=1", field_t'(1000), 1'b0);
    queue_absent();
    edge_bytes = '{8'h00, 8'hff};
    queue_bytes(edge_bytes, rand_field(), 1'b1);
    queue_text("bytes=7-3", field_t'(1000), 1'b1);
    queue_random_batch(120);
    wait_drained();

    // long receiver hold while the sender keeps going
    src_idle_pct = 0;
    hold_kick    = hold_kick + 1;
    queue_random_batch(120);
    wait_drained();

    src_idle_pct  = 47;
    sink_idle_pct = 30;
    queue_random_batch(110);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    queue_random_batch(110);
    wait_drained();

    if (fail_count == 0 && expected_ranges.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
